// ===== hdl/mxt_pkg.sv =====
// Shared types and constants for the maximum-XOR subarray trie block.
package mxt_pkg;

   localparam int WORD_W          = 32;
   localparam int DEF_MAX_ITEMS   = 1024;
   localparam int DEF_KEY_TOP_BIT = 31;
   // Wide enough for any key level up to bit 63.
   localparam int LEVEL_W         = 6;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_LOAD,
      OP_WALK,
      OP_CHECK,
      OP_PARENT,
      OP_BUILD,
      OP_QUERY,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [LEVEL_W-1:0]   level;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic ovf;
      logic qstop;
      logic out_free;
   } status_type;

endpackage

// ===== hdl/max_xor_subarray_trie.sv =====
// Each request XORs its element into a running prefix, inserts that prefix into a binary
// trie held in a node pool and then walks the trie taking the opposite bit where it can,
// answering with the largest subarray XOR seen so far in the array. With
// K = KEY_TOP_BIT + 1 levels, each request does one pool read or write per trie level,
// first for the lookup and insert and then for the query. A prefix refused by a full
// pool skips the insert and ends its lookup at the first missing node. Requests are
// handled one at a time; the next one is taken while the previous response waits in
// the output register, and a request whose response is ready waits as long as that
// register stays full. The pool holds MAX_ITEMS * K + 1 nodes; when a prefix does not
// fit, it is not stored and pool_overflow is set. After the request flagged last, the
// prefix, best value and trie return to their empty state for the next array.
module max_xor_subarray_trie #(
   parameter int MAX_ITEMS   = mxt_pkg::DEF_MAX_ITEMS,
   parameter int KEY_TOP_BIT = mxt_pkg::DEF_KEY_TOP_BIT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [mxt_pkg::WORD_W-1:0]    req_element,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mxt_pkg::WORD_W-1:0]    rsp_best_xor,
   output logic                          rsp_pool_overflow,
   output logic                          rsp_array_done
);

   mxt_pkg::cmd_type    cmd;
   mxt_pkg::status_type status;

   mxt_ctrl #(
      .KEY_TOP_BIT (KEY_TOP_BIT)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   mxt_dp #(
      .MAX_ITEMS   (MAX_ITEMS),
      .KEY_TOP_BIT (KEY_TOP_BIT)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_element       (req_element),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_best_xor      (rsp_best_xor),
      .rsp_pool_overflow (rsp_pool_overflow),
      .rsp_array_done    (rsp_array_done)
   );

endmodule

// ===== hdl/mxt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mxt_ram #(
   parameter int WIDTH = mxt_pkg::WORD_W,
   parameter int DEPTH = mxt_pkg::DEF_MAX_ITEMS
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/mxt_ctrl.sv =====
// Sequencer for the trie walk, insert and query of one request.
module mxt_ctrl #(
   parameter int KEY_TOP_BIT = mxt_pkg::DEF_KEY_TOP_BIT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output mxt_pkg::cmd_type     cmd,
   input  mxt_pkg::status_type  status
);

   localparam int KEY_LEVELS = KEY_TOP_BIT + 1;
   localparam int LV_W       = $clog2(KEY_LEVELS);
   localparam logic [LV_W-1:0] TOP_LEVEL = LV_W'(KEY_TOP_BIT);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_CHECK,
      ST_PARENT,
      ST_BUILD,
      ST_QUERY,
      ST_FINISH
   } state_type;

   state_type         state_ff;
   logic [LV_W-1:0]   level_ff;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd.level = mxt_pkg::LEVEL_W'(level_ff);
      case (state_ff)
         ST_IDLE:   cmd.op = req_valid ? mxt_pkg::OP_LOAD : mxt_pkg::OP_IDLE;
         ST_WALK:   cmd.op = mxt_pkg::OP_WALK;
         ST_CHECK:  cmd.op = mxt_pkg::OP_CHECK;
         ST_PARENT: cmd.op = mxt_pkg::OP_PARENT;
         ST_BUILD:  cmd.op = mxt_pkg::OP_BUILD;
         ST_QUERY:  cmd.op = mxt_pkg::OP_QUERY;
         ST_FINISH: cmd.op = mxt_pkg::OP_FINISH;
         default:   cmd.op = mxt_pkg::OP_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         level_ff <= TOP_LEVEL;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_WALK;
                  level_ff <= TOP_LEVEL;
               end
            end
            ST_WALK: begin
               // A missing child leaves the level counter at the first level to build.
               if (!status.hit) begin
                  state_ff <= ST_CHECK;
               end else if (level_ff == '0) begin
                  state_ff <= ST_QUERY;
                  level_ff <= TOP_LEVEL;
               end else begin
                  level_ff <= level_ff - 1'b1;
               end
            end
            ST_CHECK: begin
               if (status.ovf) begin
                  state_ff <= ST_QUERY;
                  level_ff <= TOP_LEVEL;
               end else begin
                  state_ff <= ST_PARENT;
               end
            end
            ST_PARENT: begin
               state_ff <= ST_BUILD;
            end
            ST_BUILD: begin
               if (level_ff == '0) begin
                  state_ff <= ST_QUERY;
                  level_ff <= TOP_LEVEL;
               end else begin
                  level_ff <= level_ff - 1'b1;
               end
            end
            ST_QUERY: begin
               if (status.qstop || level_ff == '0) begin
                  state_ff <= ST_FINISH;
               end else begin
                  level_ff <= level_ff - 1'b1;
               end
            end
            ST_FINISH: begin
               if (status.out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== hdl/mxt_dp.sv =====
// Datapath: prefix and best registers, trie node pool, query accumulator and result register.
module mxt_dp #(
   parameter int MAX_ITEMS   = mxt_pkg::DEF_MAX_ITEMS,
   parameter int KEY_TOP_BIT = mxt_pkg::DEF_KEY_TOP_BIT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mxt_pkg::cmd_type              cmd,
   output mxt_pkg::status_type           status,
   input  logic [mxt_pkg::WORD_W-1:0]    req_element,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [mxt_pkg::WORD_W-1:0]    rsp_best_xor,
   output logic                          rsp_pool_overflow,
   output logic                          rsp_array_done
);

   localparam int WORD_W     = mxt_pkg::WORD_W;
   localparam int KEY_LEVELS = KEY_TOP_BIT + 1;
   localparam int LV_W       = $clog2(KEY_LEVELS);
   localparam int POOL_SIZE  = MAX_ITEMS * KEY_LEVELS + 1;
   localparam int IDX_W      = $clog2(POOL_SIZE);
   localparam int NU_W       = $clog2(POOL_SIZE + 1);
   localparam int ENT_W      = 2 * IDX_W;

   // Control state.
   logic [WORD_W-1:0]     prefix_ff, prefix_in;
   logic [WORD_W-1:0]     best_ff, best_in;
   logic [NU_W-1:0]       nodes_used_ff, nodes_used_in;
   logic [ENT_W-1:0]      root_ff, root_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // Working registers for the current request.
   logic                  last_ff, last_in;
   logic                  ovf_ff, ovf_in;
   logic [IDX_W-1:0]      node_ff, node_in;
   logic [IDX_W-1:0]      miss_node_ff, miss_node_in;
   logic [ENT_W-1:0]      miss_kids_ff, miss_kids_in;
   logic [KEY_LEVELS-1:0] acc_ff, acc_in;
   logic [WORD_W-1:0]     rsp_best_ff, rsp_best_in;
   logic                  rsp_ovf_ff, rsp_ovf_in;
   logic                  rsp_done_ff, rsp_done_in;

   logic [LV_W-1:0]       lv, lv_dn;
   logic [KEY_LEVELS-1:0] key_ext;
   logic                  bit_cur, bit_nxt;
   logic [ENT_W-1:0]      cur_kids, rd_data, par_data, build_data, wr_data;
   logic [IDX_W-1:0]      same_kid, other_kid, nx, new_ptr, next_ptr, wr_addr;
   logic                  wr_en;
   logic [NU_W:0]         need_sum;
   logic                  ovf_now, out_free;
   logic [WORD_W-1:0]     q_word, best_q, best_new;

   assign lv       = cmd.level[LV_W-1:0];
   assign lv_dn    = lv - 1'b1;
   assign key_ext  = KEY_LEVELS'(prefix_ff);
   assign bit_cur  = key_ext[lv];
   assign bit_nxt  = key_ext[lv_dn];

   // Node index zero is the root, which lives in flip-flops rather than the pool.
   assign cur_kids  = (node_ff == '0) ? root_ff : rd_data;
   assign same_kid  = bit_cur ? cur_kids[ENT_W-1:IDX_W] : cur_kids[IDX_W-1:0];
   assign other_kid = bit_cur ? cur_kids[IDX_W-1:0] : cur_kids[ENT_W-1:IDX_W];
   assign nx = (cmd.op == mxt_pkg::OP_QUERY && other_kid != '0) ? other_kid : same_kid;

   assign need_sum = (NU_W + 1)'(lv) + (NU_W + 1)'(1) + {1'b0, nodes_used_ff};
   assign ovf_now  = need_sum > (NU_W + 1)'(POOL_SIZE);

   assign new_ptr  = nodes_used_ff[IDX_W-1:0];
   assign next_ptr = IDX_W'(nodes_used_ff + 1'b1);
   assign par_data = bit_cur ? {new_ptr, miss_kids_ff[IDX_W-1:0]}
                             : {miss_kids_ff[ENT_W-1:IDX_W], new_ptr};

   always_comb begin
      if (lv == '0) begin
         build_data = '0;
      end else if (bit_nxt) begin
         build_data = {next_ptr, {IDX_W{1'b0}}};
      end else begin
         build_data = {{IDX_W{1'b0}}, next_ptr};
      end
   end

   assign wr_en   = (cmd.op == mxt_pkg::OP_BUILD) ||
                    (cmd.op == mxt_pkg::OP_PARENT && miss_node_ff != '0);
   assign wr_addr = (cmd.op == mxt_pkg::OP_BUILD) ? new_ptr : miss_node_ff;
   assign wr_data = (cmd.op == mxt_pkg::OP_BUILD) ? build_data : par_data;

   mxt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (POOL_SIZE)
   ) u_pool (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (nx),
      .rd_data (rd_data)
   );

   assign q_word   = WORD_W'(acc_ff);
   assign best_q   = (q_word > best_ff) ? q_word : best_ff;
   assign best_new = (prefix_ff > best_q) ? prefix_ff : best_q;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign status.hit      = (same_kid != '0);
   assign status.ovf      = ovf_now;
   assign status.qstop    = (same_kid == '0) && (other_kid == '0);
   assign status.out_free = out_free;

   always_comb begin
      prefix_in     = prefix_ff;
      best_in       = best_ff;
      nodes_used_in = nodes_used_ff;
      root_in       = root_ff;
      rsp_valid_in  = rsp_valid_ff;
      last_in       = last_ff;
      ovf_in        = ovf_ff;
      node_in       = node_ff;
      miss_node_in  = miss_node_ff;
      miss_kids_in  = miss_kids_ff;
      acc_in        = acc_ff;
      rsp_best_in   = rsp_best_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_done_in   = rsp_done_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (cmd.op)
         mxt_pkg::OP_LOAD: begin
            prefix_in = prefix_ff ^ req_element;
            last_in   = req_last;
            ovf_in    = 1'b0;
            acc_in    = '0;
            node_in   = '0;
         end
         mxt_pkg::OP_WALK: begin
            if (status.hit && lv != '0) begin
               node_in = nx;
            end else begin
               node_in = '0;
            end
            if (!status.hit) begin
               miss_node_in = node_ff;
               miss_kids_in = cur_kids;
            end
         end
         mxt_pkg::OP_CHECK: begin
            ovf_in = ovf_now;
         end
         mxt_pkg::OP_PARENT: begin
            if (miss_node_ff == '0) begin
               root_in = par_data;
            end
         end
         mxt_pkg::OP_BUILD: begin
            nodes_used_in = nodes_used_ff + 1'b1;
         end
         mxt_pkg::OP_QUERY: begin
            if (!status.qstop) begin
               acc_in[lv] = (other_kid != '0);
               node_in    = nx;
            end
         end
         mxt_pkg::OP_FINISH: begin
            node_in = '0;
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_best_in  = best_new;
               rsp_ovf_in   = ovf_ff;
               rsp_done_in  = last_ff;
               // The final element of an array returns the trie to an empty root.
               if (last_ff) begin
                  prefix_in     = '0;
                  best_in       = '0;
                  nodes_used_in = NU_W'(1);
                  root_in       = '0;
               end else begin
                  best_in = best_new;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff     <= '0;
         best_ff       <= '0;
         nodes_used_ff <= NU_W'(1);
         root_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         node_ff       <= '0;
      end else begin
         prefix_ff     <= prefix_in;
         best_ff       <= best_in;
         nodes_used_ff <= nodes_used_in;
         root_ff       <= root_in;
         rsp_valid_ff  <= rsp_valid_in;
         node_ff       <= node_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      ovf_ff       <= ovf_in;
      miss_node_ff <= miss_node_in;
      miss_kids_ff <= miss_kids_in;
      acc_ff       <= acc_in;
      rsp_best_ff  <= rsp_best_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_best_xor      = rsp_best_ff;
   assign rsp_pool_overflow = rsp_ovf_ff;
   assign rsp_array_done    = rsp_done_ff;

endmodule
